FILE: rtl/core/ycc_up_pkg.sv
// ---------------------------------------------------------------------------
// ycc_up_pkg : shared types and constants for the 4:2:0 chroma upsampler
// Holds the stream phase encoding, configuration register indexes, the
// pixel record and the rounding-down mean used by the interpolation.
// ---------------------------------------------------------------------------
`default_nettype none

package ycc_up_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	// Configuration register indexes
	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	localparam logic [10:0] WIDTH_RESET  = 11'd768;
	localparam logic [12:0] HEIGHT_RESET = 13'd512;

	localparam int OUT_DEPTH = 4;

	typedef enum logic [1:0] {
		PH_LUMA = 2'd0,
		PH_BLUE = 2'd1,
		PH_RED  = 2'd2
	} phase_t;

	// Row group of a pixel issued for one Cr transaction
	typedef enum logic [1:0] {
		GRP_ODD   = 2'd0,
		GRP_EVEN  = 2'd1,
		GRP_FINAL = 2'd2
	} grp_t;

	typedef struct packed {
		logic [11:0] row;
		logic [9:0]  col;
		logic [7:0]  luma;
		logic [7:0]  cb;
		logic [7:0]  cr;
		logic        run_end;
		logic        frame_end;
	} pix_t;

	function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8:1];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ycc420_chroma_upsampler_core.sv
// ---------------------------------------------------------------------------
// ycc420_chroma_upsampler_core : 4:2:0 to 4:4:4 chroma upsampler
// Luma, Cb and Cr bytes are taken one per cycle while in_stall is low. Each
// Cr transaction expands into one to nine pixels, issued one per cycle
// through a memory read stage while the output queue has room. A Cr byte
// stalls the input until all the pixels it completes are issued, as each
// line store has a single read port. The output queue hands out one pixel
// per cycle while it is not empty and out_stall is low.
// Reset clears phase, counters and output queue; line stores are undefined.
// ---------------------------------------------------------------------------
`default_nettype none

module ycc420_chroma_upsampler_core
	import ycc_up_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [12:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  src_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [11:0]      pix_row,
	output logic [9:0]       pix_col,
	output logic [7:0]       luma,
	output logic [7:0]       chroma_blue,
	output logic [7:0]       chroma_red,
	output logic             run_end,
	output logic             frame_end
);

	// Line stores
	logic [7:0]  pls_mem   [2*MAX_WIDTH];
	logic [7:0]  held_mem  [MAX_WIDTH];
	logic [7:0]  blue_mem  [MAX_WIDTH/2];
	logic [15:0] pe_mem    [MAX_WIDTH];

	logic [10:0] width_q;
	logic [12:0] height_q;
	phase_t      phase_q;
	logic [10:0] cnt_q;
	logic [10:0] pc_q;
	logic [7:0]  prev_red_q;
	logic [7:0]  bn_last_q;

	// Cr transaction held while its pixels are issued
	logic        job_active_q;
	logic [10:0] job_k_q;
	logic [7:0]  job_b_q;
	logic [7:0]  job_crmid_q;
	logic [10:0] job_pc_q;
	logic        job_last_q;
	logic        job_final_q;
	logic        job_bn_zero_q;
	grp_t        seq_g_q;
	logic [1:0]  seq_i_q;

	logic [7:0]  pls_rd_q;
	logic [7:0]  held_rd_q;
	logic [7:0]  blue_rd_q;
	logic [15:0] pe_rd_q;

	logic        held_we_s1;
	logic [9:0]  held_addr_s1;

	// Output queue
	pix_t        fifo_q [OUT_DEPTH];
	logic [1:0]  wr_ptr_q;
	logic [1:0]  rd_ptr_q;
	logic [2:0]  count_q;

	// Second stage of pixel issue
	logic        v_s2;
	grp_t        g_s2;
	logic [11:0] row_s2;
	logic [9:0]  col_s2;
	logic [7:0]  cb_s2;
	logic [7:0]  cr_s2;
	logic        lz_s2;
	logic        pz_s2;
	logic        re_s2;
	logic        fe_s2;

	logic [10:0] w_eff;
	logic [12:0] h_eff;
	logic [10:0] w_even;
	logic [12:0] h_even;
	logic [9:0]  half;
	logic        in_fire;
	logic [11:0] k_inc;
	logic        luma_end;
	logic        half_end;
	logic        final_pair;
	logic [10:0] held_diff;

	logic [11:0] k2;
	logic        have_mid;
	logic        ext;
	logic [1:0]  nc_m1;
	logic [11:0] col;
	logic        is_mid;
	logic [11:0] lcol;
	logic [7:0]  bn;
	logic [7:0]  cbv;
	logic [7:0]  crv;
	grp_t        g_end;
	logic        issue;
	logic        op_last;
	logic [11:0] row_c;
	logic        pls_re;
	logic [10:0] pls_ra;
	logic        luma_zero;
	logic        pe_zero;
	logic        pop;
	pix_t        pix_new;
	logic [7:0]  luma_s2;

	// Round the frame size down to even and clamp it to the supported range
	always_comb begin
		w_even = width_q & 11'h7FE;
		h_even = height_q & 13'h1FFE;
		if (w_even < 11'd4) begin
			w_eff = 11'd4;
		end else if (w_even > 11'(MAX_WIDTH)) begin
			w_eff = 11'(MAX_WIDTH);
		end else begin
			w_eff = w_even;
		end
		if (h_even < 13'd4) begin
			h_eff = 13'd4;
		end else if (h_even > 13'(MAX_HEIGHT)) begin
			h_eff = 13'(MAX_HEIGHT);
		end else begin
			h_eff = h_even;
		end
	end

	assign half       = w_eff[10:1];
	assign in_stall   = job_active_q;
	assign in_fire    = in_valid && !in_stall;
	assign k_inc      = {1'b0, cnt_q} + 12'd1;
	assign luma_end   = k_inc >= {w_eff, 1'b0};
	assign half_end   = k_inc >= {2'b00, half};
	assign final_pair = ({1'b0, pc_q} + 12'd1) >= h_eff[12:1];
	assign held_diff  = cnt_q - w_eff;

	// Columns completed by the current Cr transaction, their pixel values and store read controls
	always_comb begin
		k2       = {job_k_q, 1'b0};
		have_mid = job_k_q != 11'd0;
		ext      = job_last_q && ((k2 + 12'd2) == {1'b0, w_eff});
		nc_m1    = {1'b0, have_mid} + {1'b0, ext};
		is_mid   = have_mid && (seq_i_q == 2'd0);
		if (is_mid) begin
			col = k2 - 12'd1;
		end else if ((have_mid && seq_i_q == 2'd1) || (!have_mid && seq_i_q == 2'd0)) begin
			col = k2;
		end else begin
			col = {1'b0, w_eff} - 12'd1;
		end
		lcol = ((col + 12'd1) == {1'b0, w_eff}) ? col - 12'd1 : col;
		bn   = job_bn_zero_q ? 8'd0 : blue_rd_q;
		cbv  = is_mid ? avg8(bn_last_q, bn) : bn;
		crv  = is_mid ? job_crmid_q : job_b_q;
		g_end   = job_final_q ? GRP_FINAL : GRP_EVEN;
		issue   = job_active_q && (({1'b0, count_q} + {3'b000, v_s2}) < 4'(OUT_DEPTH));
		op_last = (seq_i_q == nc_m1) && (seq_g_q == g_end);
		case (seq_g_q)
			GRP_ODD:   row_c = {job_pc_q, 1'b0} - 12'd1;
			GRP_EVEN:  row_c = {job_pc_q, 1'b0};
			GRP_FINAL: row_c = {job_pc_q, 1'b0} + 12'd1;
			default:   row_c = {job_pc_q, 1'b0};
		endcase
		luma_zero = (seq_g_q == GRP_ODD) ? (lcol >= 12'(MAX_WIDTH)) :
			(lcol >= 12'(2*MAX_WIDTH));
		pe_zero = col >= 12'(MAX_WIDTH);
		// Share the pair store read port between luma bytes and pixel issue
		if (job_active_q) begin
			pls_re = issue && (seq_g_q != GRP_ODD);
			pls_ra = lcol[10:0];
		end else begin
			pls_re = in_fire && (phase_q == PH_LUMA);
			pls_ra = cnt_q;
		end
	end

	// Pair luma store: read old data, write incoming luma
	always_ff @(posedge clk) begin
		if (pls_re) begin
			pls_rd_q <= pls_mem[pls_ra];
		end
		if (in_fire && phase_q == PH_LUMA) begin
			pls_mem[cnt_q] <= src_byte;
		end
	end

	// Held odd-row luma: copy of the previous pair's odd row
	always_ff @(posedge clk) begin
		if (issue && seq_g_q == GRP_ODD) begin
			held_rd_q <= held_mem[lcol[9:0]];
		end
		if (held_we_s1) begin
			held_mem[held_addr_s1] <= pls_rd_q;
		end
	end

	// Cb samples of the current pair
	always_ff @(posedge clk) begin
		if (in_fire && phase_q == PH_RED && cnt_q < 11'(MAX_WIDTH/2)) begin
			blue_rd_q <= blue_mem[cnt_q[8:0]];
		end
		if (in_fire && phase_q == PH_BLUE && cnt_q < 11'(MAX_WIDTH/2)) begin
			blue_mem[cnt_q[8:0]] <= src_byte;
		end
	end

	// Even-row chroma of the previous pair
	always_ff @(posedge clk) begin
		if (issue && seq_g_q == GRP_ODD) begin
			pe_rd_q <= pe_mem[col[9:0]];
		end
		if (issue && seq_g_q == GRP_EVEN && !pe_zero) begin
			pe_mem[col[9:0]] <= {cbv, crv};
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data[10:0];
				CFG_HEIGHT: height_q <= cfg_data;
				default:    width_q  <= width_q;
			endcase
		end
	end

	// Stream position and Cr transaction capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_LUMA;
			cnt_q        <= '0;
			pc_q         <= '0;
			prev_red_q   <= '0;
			bn_last_q    <= '0;
			job_active_q <= 1'b0;
			seq_g_q      <= GRP_EVEN;
			seq_i_q      <= '0;
			held_we_s1   <= 1'b0;
		end else begin
			held_we_s1 <= in_fire && (phase_q == PH_LUMA) && (cnt_q >= w_eff)
				&& !held_diff[10];
			if (in_fire) begin
				case (phase_q)
					PH_LUMA: begin
						phase_q    <= luma_end ? PH_BLUE : PH_LUMA;
						cnt_q      <= luma_end ? 11'd0 : k_inc[10:0];
					end
					PH_BLUE: begin
						phase_q <= half_end ? PH_RED : PH_BLUE;
						cnt_q   <= half_end ? 11'd0 : k_inc[10:0];
					end
					PH_RED: begin
						prev_red_q   <= src_byte;
						job_active_q <= 1'b1;
						seq_g_q      <= (pc_q != 11'd0) ? GRP_ODD : GRP_EVEN;
						seq_i_q      <= '0;
						if (half_end) begin
							phase_q <= PH_LUMA;
							cnt_q   <= '0;
							pc_q    <= final_pair ? 11'd0 : pc_q + 11'd1;
						end else begin
							cnt_q <= k_inc[10:0];
						end
					end
					default: phase_q <= PH_LUMA;
				endcase
			end
			// Advance through the pixels of the held Cr transaction
			if (issue) begin
				if (seq_i_q == nc_m1) begin
					seq_i_q <= '0;
					if (seq_g_q == g_end) begin
						job_active_q <= 1'b0;
						bn_last_q    <= bn;
					end else begin
						seq_g_q <= grp_t'(seq_g_q + 2'd1);
					end
				end else begin
					seq_i_q <= seq_i_q + 2'd1;
				end
			end
		end
	end

	// Payload of the held transaction, held-store write address and second-stage registers
	always_ff @(posedge clk) begin
		if (in_fire && phase_q == PH_LUMA) begin
			held_addr_s1 <= held_diff[9:0];
		end
		if (in_fire && phase_q == PH_RED) begin
			job_k_q       <= cnt_q;
			job_b_q       <= src_byte;
			job_crmid_q   <= avg8(prev_red_q, src_byte);
			job_pc_q      <= pc_q;
			job_last_q    <= half_end;
			job_final_q   <= final_pair;
			job_bn_zero_q <= cnt_q >= 11'(MAX_WIDTH/2);
		end
		g_s2   <= seq_g_q;
		row_s2 <= row_c;
		col_s2 <= col[9:0];
		cb_s2  <= cbv;
		cr_s2  <= crv;
		lz_s2  <= luma_zero;
		pz_s2  <= pe_zero;
		re_s2  <= op_last;
		fe_s2  <= op_last && job_final_q && job_last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= issue;
		end
	end

	// Form the pixel from the store read data
	always_comb begin
		if (lz_s2) begin
			luma_s2 = 8'd0;
		end else if (g_s2 == GRP_ODD) begin
			luma_s2 = held_rd_q;
		end else begin
			luma_s2 = pls_rd_q;
		end
		pix_new.row       = row_s2;
		pix_new.col       = col_s2;
		pix_new.luma      = luma_s2;
		pix_new.run_end   = re_s2;
		pix_new.frame_end = fe_s2;
		if (g_s2 == GRP_ODD) begin
			pix_new.cb = avg8(pz_s2 ? 8'd0 : pe_rd_q[15:8], cb_s2);
			pix_new.cr = avg8(pz_s2 ? 8'd0 : pe_rd_q[7:0], cr_s2);
		end else begin
			pix_new.cb = cb_s2;
			pix_new.cr = cr_s2;
		end
	end

	// Output queue: push formed pixels, drop them once taken
	assign out_valid = count_q != 3'd0;
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (v_s2) begin
			fifo_q[wr_ptr_q] <= pix_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (v_s2) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + {2'b00, v_s2} - {2'b00, pop};
		end
	end

	assign pix_row     = fifo_q[rd_ptr_q].row;
	assign pix_col     = fifo_q[rd_ptr_q].col;
	assign luma        = fifo_q[rd_ptr_q].luma;
	assign chroma_blue = fifo_q[rd_ptr_q].cb;
	assign chroma_red  = fifo_q[rd_ptr_q].cr;
	assign run_end     = fifo_q[rd_ptr_q].run_end;
	assign frame_end   = fifo_q[rd_ptr_q].frame_end;

endmodule

`default_nettype wire
